[hw/rtl/hnm_pkg.sv]
// shared types, constants and arithmetic steps of the height to normal map block
package hnm_pkg;

  localparam int GRAD_W  = 24;
  localparam int SQ_W    = 48;
  localparam int SQ_STEPS = 24;
  localparam int DIV_STEPS = 9;
  localparam int NUM_W   = 25;
  localparam int REM_W   = 34;
  localparam int QUEUE_DEPTH = 8;
  localparam int QPTR_W  = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W  = QPTR_W + 1;
  localparam logic [23:0] RECIP_255 = 24'h808081;

  localparam logic [2:0] REG_IMAGE_WIDTH   = 3'd0;
  localparam logic [2:0] REG_BUMP_STRENGTH = 3'd4;

  typedef struct packed {
    logic [GRAD_W-1:0] ux;
    logic [GRAD_W-1:0] uy;
    logic              sx;
    logic              sy;
    logic              last;
  } grad_t;

  typedef struct packed {
    logic [SQ_W-1:0] v;
    logic [SQ_W-1:0] res;
  } sq_t;

  typedef struct packed {
    logic [REM_W-1:0]     rem;
    logic [DIV_STEPS-1:0] q;
  } div_t;

  function automatic sq_t sqrt_step(sq_t s, int k);
    logic [SQ_W-1:0] bitv;
    logic [SQ_W-1:0] trial;
    sq_t o;
    bitv  = SQ_W'(1) << (2 * (SQ_STEPS - 1 - k));
    trial = s.res + bitv;
    if (s.v >= trial) begin
      o.v   = s.v - trial;
      o.res = (s.res >> 1) + bitv;
    end else begin
      o.v   = s.v;
      o.res = s.res >> 1;
    end
    return o;
  endfunction

  function automatic div_t div_step(div_t d, logic [NUM_W-1:0] den, int k);
    logic [REM_W-1:0] t;
    div_t o;
    t = REM_W'(den) << (DIV_STEPS - 1 - k);
    o = d;
    if (d.rem >= t) begin
      o.rem = d.rem - t;
      o.q[DIV_STEPS-1-k] = 1'b1;
    end
    return o;
  endfunction

endpackage

[hw/rtl/hnm_ram.sv]
// generic single write, single read ram with registered read data
module hnm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

[hw/rtl/hnm_queue.sv]
// short register queue of gradient items between front and back
module hnm_queue (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  hnm_pkg::grad_t         push_data,
  input  logic                   pop,
  output hnm_pkg::grad_t         head,
  output logic                   empty,
  output logic [hnm_pkg::QCNT_W-1:0] count
);
  import hnm_pkg::*;

  grad_t             mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wp_r, rp_r;
  logic [QCNT_W-1:0] cnt_r;
  logic              do_pop;

  assign empty  = (cnt_r == '0);
  assign count  = cnt_r;
  assign head   = mem_r[rp_r];
  assign do_pop = pop && !empty;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + QPTR_W'(1);
      if (do_pop) rp_r <= rp_r + QPTR_W'(1);
      cnt_r <= cnt_r + QCNT_W'(push) - QCNT_W'(do_pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (cnt_r != QCNT_W'(QUEUE_DEPTH)) || do_pop)
    else $error("queue overflow");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count out of range");

  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> (cnt_r == '0))
    else $error("queue not empty after reset");
endmodule

[hw/rtl/hnm_front.sv]
// front part: row buffers, neighbour selection and gradient computation
module hnm_front #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_kind,
  input  logic [7:0]                 in_height_sample,
  input  logic [10:0]                image_width,
  input  logic [15:0]                bump_strength,
  input  logic [hnm_pkg::QCNT_W-1:0] q_count,
  output logic                       push,
  output hnm_pkg::grad_t             push_data
);
  import hnm_pkg::*;

  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int CW = ($clog2(MAX_WIDTH + 1) > 11) ? $clog2(MAX_WIDTH + 1) + 1 : 12;

  logic [AW-1:0] col_r;
  logic [1:0]    rows_r;
  logic [7:0]    prev_r;

  logic          take, row_end;
  logic [CW-1:0] iw_e, w_use;
  logic [AW-1:0] c_next;

  logic          s1_v_r, s1_drain_r, s1_emit_r, s1_up_r, s1_first_r, s1_end_r, s1_last_r;
  logic [AW-1:0] s1_c_r;
  logic [7:0]    s1_samp_r;
  logic          byp_ma_r, byp_mb_r, byp_u_r;
  logic [7:0]    byp_ma_v_r, byp_mb_v_r, byp_u_v_r;
  logic [7:0]    ma_q, mb_q, u_q;
  logic [7:0]    m1, r1, u1, d1, l1;
  logic          mwe, uwe;
  logic signed [8:0] dx9, dy9;

  logic                     s2_v_r, s2_last_r;
  logic signed [24:0]       px_r, py_r;
  logic [GRAD_W-1:0]        ax, ay;
  logic [47:0]              prx, pry;

  logic                     s3_v_r, s3_last_r, s3_sx_r, s3_sy_r;
  logic [GRAD_W-1:0]        s3_ax_r, s3_ay_r;
  logic [16:0]              s3_rx_r, s3_ry_r;
  logic [QCNT_W:0]          occ;

  assign occ      = (QCNT_W+1)'(q_count) + (QCNT_W+1)'(s1_v_r) + (QCNT_W+1)'(s2_v_r)
                  + (QCNT_W+1)'(s3_v_r);
  assign in_ready = occ < (QCNT_W+1)'(QUEUE_DEPTH);

  assign take   = in_valid && in_ready && !(rows_r == 2'd0 && in_kind);
  assign iw_e   = CW'(image_width);
  assign w_use  = (iw_e == '0) ? CW'(1) : ((iw_e > CW'(MAX_WIDTH)) ? CW'(MAX_WIDTH) : iw_e);
  assign row_end = (CW'(col_r) + CW'(1)) >= w_use;
  assign c_next = col_r + AW'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      rows_r <= 2'd0;
    end else if (take) begin
      if (row_end) begin
        col_r <= '0;
        if (rows_r == 2'd0) begin
          rows_r <= 2'd1;
        end else if (in_kind) begin
          rows_r <= 2'd0;
        end else if (rows_r != 2'd2) begin
          rows_r <= rows_r + 2'd1;
        end
      end else begin
        col_r <= c_next;
      end
    end
  end

  assign mwe = s1_v_r && !s1_drain_r;
  assign uwe = s1_v_r && s1_emit_r && !s1_drain_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_drain_r <= in_kind;
      s1_emit_r  <= (rows_r != 2'd0);
      s1_up_r    <= (rows_r == 2'd2);
      s1_first_r <= (col_r == '0);
      s1_end_r   <= row_end;
      s1_last_r  <= in_kind && row_end;
      s1_c_r     <= col_r;
      s1_samp_r  <= in_height_sample;
      byp_ma_r   <= mwe && (s1_c_r == col_r);
      byp_mb_r   <= mwe && (s1_c_r == c_next);
      byp_u_r    <= uwe && (s1_c_r == col_r);
      byp_ma_v_r <= s1_samp_r;
      byp_mb_v_r <= s1_samp_r;
      byp_u_v_r  <= m1;
    end
  end

  hnm_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_mid_a (
    .clk(clk), .we(mwe), .waddr(s1_c_r), .wdata(s1_samp_r),
    .re(take), .raddr(col_r), .rdata(ma_q)
  );

  hnm_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_mid_b (
    .clk(clk), .we(mwe), .waddr(s1_c_r), .wdata(s1_samp_r),
    .re(take), .raddr(c_next), .rdata(mb_q)
  );

  hnm_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_up (
    .clk(clk), .we(uwe), .waddr(s1_c_r), .wdata(m1),
    .re(take), .raddr(col_r), .rdata(u_q)
  );

  always_comb begin
    m1  = byp_ma_r ? byp_ma_v_r : ma_q;
    r1  = s1_end_r ? m1 : (byp_mb_r ? byp_mb_v_r : mb_q);
    u1  = s1_up_r ? (byp_u_r ? byp_u_v_r : u_q) : m1;
    d1  = s1_drain_r ? m1 : s1_samp_r;
    l1  = s1_first_r ? m1 : prev_r;
    dx9 = $signed({1'b0, r1}) - $signed({1'b0, l1});
    dy9 = $signed({1'b0, d1}) - $signed({1'b0, u1});
  end

  always_ff @(posedge clk) begin
    if (s1_v_r && s1_emit_r) begin
      prev_r <= m1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      s2_v_r <= s1_v_r && s1_emit_r;
      s3_v_r <= s2_v_r;
    end
  end

  assign ax  = px_r[24] ? GRAD_W'(-px_r) : GRAD_W'(px_r);
  assign ay  = py_r[24] ? GRAD_W'(-py_r) : GRAD_W'(py_r);
  assign prx = ax * RECIP_255;
  assign pry = ay * RECIP_255;

  always_ff @(posedge clk) begin
    px_r      <= dx9 * $signed(bump_strength);
    py_r      <= dy9 * $signed(bump_strength);
    s2_last_r <= s1_last_r;
    s3_ax_r   <= ax;
    s3_ay_r   <= ay;
    s3_rx_r   <= prx[47:31];
    s3_ry_r   <= pry[47:31];
    s3_sx_r   <= px_r[24];
    s3_sy_r   <= py_r[24];
    s3_last_r <= s2_last_r;
  end

  assign push           = s3_v_r;
  assign push_data.ux   = s3_ax_r + GRAD_W'(s3_rx_r);
  assign push_data.uy   = s3_ay_r + GRAD_W'(s3_ry_r);
  assign push_data.sx   = s3_sx_r;
  assign push_data.sy   = s3_sy_r;
  assign push_data.last = s3_last_r;
endmodule

[hw/rtl/hnm_back.sv]
// back part: vector length by pipelined square root and byte mapping by pipelined division
module hnm_back (
  input  logic           clk,
  input  logic           rst_n,
  input  hnm_pkg::grad_t head,
  input  logic           q_empty,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [7:0]     out_normal_x,
  output logic [7:0]     out_normal_y,
  output logic [7:0]     out_normal_z,
  output logic           out_last_of_frame
);
  import hnm_pkg::*;

  localparam int NST = 2 + SQ_STEPS + 1 + DIV_STEPS + 1;

  logic [NST-1:0]   vld_r;
  logic             en;

  grad_t            c0_r;
  logic [SQ_W-1:0]  sqx_r, sqy_r;
  sq_t              sq_r [SQ_STEPS+1];
  grad_t            cs_r [SQ_STEPS+1];
  div_t             dvx_r [DIV_STEPS+1];
  div_t             dvy_r [DIV_STEPS+1];
  div_t             dvz_r [DIV_STEPS+1];
  logic [NUM_W-1:0] den_r [DIV_STEPS+1];
  logic             lst_r [DIV_STEPS+1];

  logic [NUM_W-1:0] len_e, nx, ny, nz;

  assign out_valid = vld_r[NST-1];
  assign en        = !out_valid || out_ready;
  assign pop       = en && !q_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NST-2:0], pop};
    end
  end

  assign len_e = NUM_W'(sq_r[SQ_STEPS].res[GRAD_W-1:0]);
  assign nx = cs_r[SQ_STEPS].sx ? len_e + NUM_W'(cs_r[SQ_STEPS].ux)
                                : len_e - NUM_W'(cs_r[SQ_STEPS].ux);
  assign ny = cs_r[SQ_STEPS].sy ? len_e + NUM_W'(cs_r[SQ_STEPS].uy)
                                : len_e - NUM_W'(cs_r[SQ_STEPS].uy);
  assign nz = len_e + NUM_W'(65536);

  always_ff @(posedge clk) begin
    if (en) begin
      c0_r  <= head;
      sqx_r <= head.ux * head.ux;
      sqy_r <= head.uy * head.uy;

      sq_r[0].v   <= sqx_r + sqy_r + (SQ_W'(1) << 32);
      sq_r[0].res <= '0;
      cs_r[0]     <= c0_r;
      for (int k = 0; k < SQ_STEPS; k++) begin
        sq_r[k+1] <= sqrt_step(sq_r[k], k);
        cs_r[k+1] <= cs_r[k];
      end

      dvx_r[0].rem <= (REM_W'(nx) << 8) - REM_W'(nx);
      dvy_r[0].rem <= (REM_W'(ny) << 8) - REM_W'(ny);
      dvz_r[0].rem <= (REM_W'(nz) << 8) - REM_W'(nz);
      dvx_r[0].q   <= '0;
      dvy_r[0].q   <= '0;
      dvz_r[0].q   <= '0;
      den_r[0]     <= len_e << 1;
      lst_r[0]     <= cs_r[SQ_STEPS].last;
      for (int k = 0; k < DIV_STEPS; k++) begin
        dvx_r[k+1] <= div_step(dvx_r[k], den_r[k], k);
        dvy_r[k+1] <= div_step(dvy_r[k], den_r[k], k);
        dvz_r[k+1] <= div_step(dvz_r[k], den_r[k], k);
        den_r[k+1] <= den_r[k];
        lst_r[k+1] <= lst_r[k];
      end

      out_normal_x      <= dvx_r[DIV_STEPS].q[8] ? 8'hFF : dvx_r[DIV_STEPS].q[7:0];
      out_normal_y      <= dvy_r[DIV_STEPS].q[8] ? 8'hFF : dvy_r[DIV_STEPS].q[7:0];
      out_normal_z      <= dvz_r[DIV_STEPS].q[8] ? 8'hFF : dvz_r[DIV_STEPS].q[7:0];
      out_last_of_frame <= lst_r[DIV_STEPS];
    end
  end
endmodule

[hw/rtl/height_to_normal_map.sv]
// top level: height map stream in, normal map stream out, apb register port
// throughput: one item per cycle while the output is not stalled, set by the
// one-item-per-cycle row buffer ports and the fully pipelined square root and
// byte division units of the back part
// reset clears counters, queue and pipeline valids; row buffers keep their contents
// registers reset to image_width 1024 and bump_strength 1.0
module height_to_normal_map #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_kind,
  input  logic [7:0]  in_height_sample,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_normal_x,
  output logic [7:0]  out_normal_y,
  output logic [7:0]  out_normal_z,
  output logic        out_last_of_frame,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import hnm_pkg::*;

  logic [10:0]       iw_r;
  logic [15:0]       bs_r;
  logic              push, pop, q_empty, wr;
  grad_t             push_data, head;
  logic [QCNT_W-1:0] q_count;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iw_r <= 11'd1024;
      bs_r <= 16'd256;
    end else if (wr) begin
      if (paddr[2] == REG_BUMP_STRENGTH[2]) begin
        bs_r <= pwdata[15:0];
      end else begin
        iw_r <= pwdata[10:0];
      end
    end
  end

  assign prdata = (paddr[2] == REG_BUMP_STRENGTH[2]) ? {16'd0, bs_r} : {21'd0, iw_r};

  hnm_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_kind(in_kind), .in_height_sample(in_height_sample),
    .image_width(iw_r), .bump_strength(bs_r),
    .q_count(q_count), .push(push), .push_data(push_data)
  );

  hnm_queue u_queue (
    .clk(clk), .rst_n(rst_n),
    .push(push), .push_data(push_data),
    .pop(pop), .head(head), .empty(q_empty), .count(q_count)
  );

  hnm_back u_back (
    .clk(clk), .rst_n(rst_n),
    .head(head), .q_empty(q_empty), .pop(pop),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_normal_x(out_normal_x), .out_normal_y(out_normal_y),
    .out_normal_z(out_normal_z), .out_last_of_frame(out_last_of_frame)
  );
endmodule

[sim/hnm_checker.sv]
// normal map predictor and result checker for the height to normal map block
module hnm_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        in_kind,
  input  logic [7:0]  in_height_sample,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [7:0]  out_normal_x,
  input  logic [7:0]  out_normal_y,
  input  logic [7:0]  out_normal_z,
  input  logic        out_last_of_frame,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          errors,
  output int          pending,
  output int          normals_seen
);
  timeunit 1ns;
  timeprecision 1ps;
  import hnm_pkg::*;

  localparam int ROW_MAX = 1024;

  typedef struct packed {
    logic [7:0] nx;
    logic [7:0] ny;
    logic [7:0] nz;
    logic       last;
  } normal_t;

  normal_t     expected_normals[$];
  logic [7:0]  upper_line[ROW_MAX];
  logic [7:0]  middle_line[ROW_MAX];
  int unsigned col;
  int unsigned rows_held;
  logic [7:0]  left_height;
  logic [10:0] width_reg;
  logic [15:0] strength_reg;

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned root;
    longint unsigned bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  function automatic logic [7:0] unit_to_byte(longint unsigned num, longint unsigned len);
    longint unsigned b;
    b = (255 * num) / (2 * len);
    return (b > 255) ? 8'd255 : b[7:0];
  endfunction

  task automatic predict_normal(logic drain, logic [7:0] sample);
    int unsigned     w;
    int unsigned     c;
    bit              row_end;
    logic [7:0]      m, u, d, l, r;
    longint          s, dx, dy;
    longint unsigned ux, uy, len;
    normal_t         n;
    w = (width_reg < 1) ? 1 : (width_reg > ROW_MAX) ? ROW_MAX : width_reg;
    c = (col >= ROW_MAX) ? ROW_MAX - 1 : col;
    row_end = (c + 1 >= w);
    if (rows_held == 0) begin
      if (!drain) begin
        middle_line[c] = sample;
        if (row_end) begin
          col = 0;
          rows_held = 1;
        end else begin
          col = c + 1;
        end
      end
      return;
    end
    m = middle_line[c];
    u = (rows_held >= 2) ? upper_line[c] : m;
    d = drain ? m : sample;
    l = (c > 0) ? left_height : m;
    r = row_end ? m : middle_line[c + 1];
    s = longint'($signed(strength_reg));
    dx = ((longint'(r) - longint'(l)) * s * 256) / 255;
    dy = ((longint'(d) - longint'(u)) * s * 256) / 255;
    ux = (dx < 0) ? -dx : dx;
    uy = (dy < 0) ? -dy : dy;
    len = int_sqrt(ux * ux + uy * uy + (64'd1 << 32));
    n.nx = unit_to_byte((dx < 0) ? len + ux : len - ux, len);
    n.ny = unit_to_byte((dy < 0) ? len + uy : len - uy, len);
    n.nz = unit_to_byte(len + 65536, len);
    n.last = drain && row_end;
    expected_normals.push_back(n);
    left_height = m;
    if (!drain) begin
      upper_line[c] = m;
      middle_line[c] = sample;
    end
    if (row_end) begin
      col = 0;
      if (drain) rows_held = 0;
      else if (rows_held < 2) rows_held++;
    end else begin
      col = c + 1;
    end
  endtask

  initial begin
    errors = 0;
    pending = 0;
    normals_seen = 0;
    for (int i = 0; i < ROW_MAX; i++) begin
      upper_line[i] = '0;
      middle_line[i] = '0;
    end
  end

  always @(posedge clk) begin
    normal_t e;
    if (!rst_n) begin
      expected_normals.delete();
      col = 0;
      rows_held = 0;
      left_height = '0;
      width_reg = 11'd1024;
      strength_reg = 16'd256;
    end else begin
      if (out_valid && out_ready) begin
        normals_seen++;
        if (expected_normals.size() == 0) begin
          $error("normal with none expected: %0d %0d %0d last %0b", out_normal_x,
                 out_normal_y, out_normal_z, out_last_of_frame);
          errors++;
        end else begin
          e = expected_normals.pop_front();
          if (out_normal_x !== e.nx) begin
            $error("normal_x expected %0d actual %0d", e.nx, out_normal_x);
            errors++;
          end
          if (out_normal_y !== e.ny) begin
            $error("normal_y expected %0d actual %0d", e.ny, out_normal_y);
            errors++;
          end
          if (out_normal_z !== e.nz) begin
            $error("normal_z expected %0d actual %0d", e.nz, out_normal_z);
            errors++;
          end
          if (out_last_of_frame !== e.last) begin
            $error("last_of_frame expected %0b actual %0b", e.last, out_last_of_frame);
            errors++;
          end
        end
      end
      if (in_valid && in_ready) predict_normal(in_kind, in_height_sample);
      if (psel && penable && pwrite && pready) begin
        case (paddr)
          REG_IMAGE_WIDTH:   width_reg = pwdata[10:0];
          REG_BUMP_STRENGTH: strength_reg = pwdata[15:0];
          default: ;
        endcase
      end
    end
    pending = expected_normals.size();
  end
endmodule

[sim/tb.sv]
// testbench top: stimulus, register setup and verdict for height_to_normal_map
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import hnm_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_WAIT  = 50;
  localparam bit HEIGHT = 1'b0;
  localparam bit DRAIN  = 1'b1;

  logic        clk;
  logic        rst_n;
  logic        in_valid, in_ready, in_kind;
  logic [7:0]  in_height_sample;
  logic        out_valid, out_ready;
  logic [7:0]  out_normal_x, out_normal_y, out_normal_z;
  logic        out_last_of_frame;
  logic        psel, penable, pwrite, pready;
  logic [2:0]  paddr;
  logic [31:0] pwdata, prdata;
  int          errors, pending, normals_seen;

  int          send_idle_pct;
  int          recv_stall_pct;
  int          hold_left;
  int          quiet_cycles;
  int          items_sent;
  int          frames_sent;

  int unsigned frame_width;
  int unsigned frame_col;
  int unsigned frame_rows;

  height_to_normal_map i_dut (
    .clk, .rst_n, .in_valid, .in_ready, .in_kind, .in_height_sample,
    .out_valid, .out_ready, .out_normal_x, .out_normal_y, .out_normal_z,
    .out_last_of_frame, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  hnm_checker i_checker (
    .clk, .rst_n, .in_valid, .in_ready, .in_kind, .in_height_sample,
    .out_valid, .out_ready, .out_normal_x, .out_normal_y, .out_normal_z,
    .out_last_of_frame, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .errors, .pending, .normals_seen
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // frame position, so register changes land between frames
  task automatic track_item(bit drain);
    int unsigned c;
    bit          row_end;
    c = (frame_col >= 1024) ? 1023 : frame_col;
    row_end = (c + 1 >= frame_width);
    if (frame_rows == 0) begin
      if (!drain) begin
        if (row_end) begin
          frame_col = 0;
          frame_rows = 1;
        end else begin
          frame_col = c + 1;
        end
      end
    end else if (row_end) begin
      frame_col = 0;
      if (drain) begin
        frame_rows = 0;
        frames_sent++;
      end else if (frame_rows < 2) begin
        frame_rows++;
      end
    end else begin
      frame_col = c + 1;
    end
  endtask

  task automatic put_item(bit kind, logic [7:0] h);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= kind;
    in_height_sample <= h;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    track_item(kind);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic reg_write(logic [2:0] addr, logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == REG_IMAGE_WIDTH) begin
      frame_width = (data[10:0] < 1) ? 1 : (data[10:0] > 1024) ? 1024 : data[10:0];
    end
  endtask

  task automatic set_frame(logic [10:0] w, logic [15:0] s);
    wait_idle();
    reg_write(REG_IMAGE_WIDTH, {21'd0, w});
    reg_write(REG_BUMP_STRENGTH, {16'd0, s});
  endtask

  task automatic finish_frame();
    while (frame_rows == 0 && frame_col != 0) put_item(HEIGHT, 8'($urandom));
    while (frame_rows != 0) put_item(DRAIN, 8'($urandom));
  endtask

  task automatic send_rows(int rows, int mode);
    for (int i = 0; i < rows * frame_width; i++) begin
      case (mode)
        0: put_item(HEIGHT, 8'($urandom));
        1: put_item(HEIGHT, (i % 2) ? 8'd255 : 8'd0);
        default: put_item(HEIGHT, ((i / frame_width) % 2) ? 8'd0 : 8'd255);
      endcase
    end
  endtask

  initial begin
    int target;
    int rows;
    logic [15:0] s;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_kind = 1'b0;
    in_height_sample = '0;
    out_ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_left = 0;
    quiet_cycles = 0;
    items_sent = 0;
    frames_sent = 0;
    frame_width = 1024;
    frame_col = 0;
    frame_rows = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: single column, extremes of gain, mid-row drain, shrinking width
    set_frame(11'd0, 16'd256);
    put_item(DRAIN, 8'hff);
    put_item(HEIGHT, 8'd0);
    put_item(HEIGHT, 8'd255);
    put_item(HEIGHT, 8'd0);
    finish_frame();
    set_frame(11'd4, 16'h7fff);
    send_rows(3, 1);
    finish_frame();
    set_frame(11'd3, 16'h8000);
    send_rows(1, 2);
    put_item(HEIGHT, 8'd255);
    put_item(HEIGHT, 8'd0);
    put_item(DRAIN, 8'd0);
    put_item(HEIGHT, 8'd128);
    finish_frame();
    set_frame(11'd6, 16'h0100);
    send_rows(1, 0);
    put_item(HEIGHT, 8'd1);
    put_item(HEIGHT, 8'd254);
    put_item(HEIGHT, 8'd77);
    put_item(HEIGHT, 8'd200);
    wait_idle();
    reg_write(REG_IMAGE_WIDTH, 32'd3);
    send_rows(1, 0);
    finish_frame();
    set_frame(11'd2047, 16'd0);
    repeat (5) put_item(HEIGHT, 8'($urandom));
    wait_idle();
    reg_write(REG_IMAGE_WIDTH, 32'd3);
    send_rows(2, 0);
    finish_frame();

    // long receiver hold-off so the block backs up into its input
    set_frame(11'd32, 16'h0280);
    hold_left = 400;
    send_rows(4, 0);
    finish_frame();

    target = 800;
    for (int f = 0; items_sent < target; f++) begin
      case (f % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 55; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 55; end
        default: begin send_idle_pct = 37; recv_stall_pct = 37; end
      endcase
      case ($urandom_range(5))
        0: s = 16'h7fff;
        1: s = 16'h8000;
        2: s = 16'($urandom_range(0, 1024));
        default: s = 16'($urandom);
      endcase
      set_frame(($urandom_range(9) == 0) ? 11'($urandom_range(17, 64))
                                         : 11'($urandom_range(1, 16)), s);
      rows = $urandom_range(1, 5);
      for (int i = 0; i < rows * frame_width; i++) begin
        if ($urandom_range(19) == 0) put_item(DRAIN, 8'($urandom));
        put_item(HEIGHT, 8'($urandom));
      end
      finish_frame();
    end

    wait_idle();
    $display("covered %0d items in %0d frames, %0d normals checked", items_sent,
             frames_sent, normals_seen);
    $display("widths 1 to 64 and an oversize width, gain at both extremes, drains mid-row");
    if (errors == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

[files.f]
hw/rtl/hnm_pkg.sv
hw/rtl/hnm_ram.sv
hw/rtl/hnm_queue.sv
hw/rtl/hnm_front.sv
hw/rtl/hnm_back.sv
hw/rtl/height_to_normal_map.sv
sim/hnm_checker.sv
sim/tb.sv
